### design/eza_pkg.sv
// Shared constants, types and tables for the ellipsoid zone area pipeline.
package eza_pkg;

    // Field widths
    localparam int LAT_W   = 24;
    localparam int AREA_W  = 64;
    localparam int ECC_W   = 32;
    localparam int ZONE_W  = 63;
    localparam int CFG_W   = 63;
    localparam int G_W     = 96;

    // Angle format and fixed-point constants
    localparam int ANGLE_FRAC_BITS = 16;
    localparam logic [31:0] LAT_LIMIT   = 32'd90 << ANGLE_FRAC_BITS;
    localparam logic [24:0] DEG2RAD_Q30 = 25'd18740330;
    localparam logic [23:0] LN2_Q24     = 24'd11629080;
    localparam logic [ECC_W-1:0] ECC_RESET = 32'd351334140;

    // Pipeline geometry
    localparam int SIN_TERMS   = 6;
    localparam int SIN_STAGES  = 3 * SIN_TERMS;
    localparam int NORM_STAGES = 5;
    localparam int LOG_STEPS   = 32;
    localparam int DIV_STEPS   = 64;
    localparam int AT_DLY      = DIV_STEPS - NORM_STAGES - LOG_STEPS - 2;
    localparam int LANE_LAT    = 6 + SIN_STAGES + DIV_STEPS + 5;
    localparam int TOP_LAT     = LANE_LAT + 1;

    // Register indexes
    typedef enum logic [0:0] {
        CFG_ECC  = 1'b0,
        CFG_ZONE = 1'b1
    } t_cfg_idx;

    // Taylor divisors (2k)(2k+1) and floor(2^33 / divisor)
    localparam logic [7:0] SIN_DIV [SIN_TERMS] = '{
        8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156
    };
    localparam logic [30:0] SIN_RECIP [SIN_TERMS] = '{
        31'd1431655765, 31'd429496729, 31'd204522252,
        31'd119304647,  31'd78090314,  31'd55063683
    };

    // Word handed between restoring division cells
    typedef struct packed {
        logic [32:0] rem;
        logic [63:0] dq;
        logic [32:0] den;
    } t_div_word;

    // Word handed between log2 squaring cells
    typedef struct packed {
        logic [5:0]  p;
        logic [31:0] m;
        logic [31:0] f;
    } t_log_word;

endpackage

### design/eza_if.sv
// Valid/ready channel interfaces for latitude pairs and zone areas.
interface eza_in_if;
    import eza_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] north_lat;
    logic signed [LAT_W-1:0] south_lat;

    modport source (output valid, output north_lat, output south_lat, input ready);
    modport sink   (input valid, input north_lat, input south_lat, output ready);
endinterface

interface eza_out_if;
    import eza_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [AREA_W-1:0] zone_area;

    modport source (output valid, output zone_area, input ready);
    modport sink   (input valid, input zone_area, output ready);
endinterface

### design/ellipsoid_zone_area.sv
// Top level: config registers, two latitude lanes, difference, saturation, output skid.
//
// Ellipsoid zone area between two latitudes.
// Input channel i_lat carries a word of north_lat and south_lat (signed,
// degrees * 65536); output channel o_area carries zone_area (signed,
// 1/65536 m^2, saturated to the 64-bit range). Both are valid/ready.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 = eccentricity Q0.32, 1 = zone factor); write only while idle.
// Throughput: one word per cycle while the skid register is empty. The
// latency is set by the 64-cell restoring divider chain, plus the sine,
// scaling and multiply stages around it; the two log2 chains of 32
// squaring cells run beside the divider.
// Stall: one output register plus one skid register; the input keeps
// accepting while a result waits, and the whole pipeline freezes only
// when the skid register is occupied.
// Reset (synchronous, active low) clears all valid flags and loads the
// register reset values; no clearing pass is needed.
module ellipsoid_zone_area import eza_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    eza_in_if.sink            i_lat,
    eza_out_if.source         o_area
);

    logic [ECC_W-1:0]         r_ecc;
    logic [ZONE_W-1:0]        r_zone;
    logic                     r_vld [TOP_LAT];
    logic                     w_en;
    logic signed [G_W-1:0]    w_gn;
    logic signed [G_W-1:0]    w_gs;
    logic signed [G_W:0]      w_diff;
    logic [AREA_W-1:0]        n_res;
    logic [AREA_W-1:0]        r_res;
    logic                     r_out_vld;
    logic                     n_out_vld;
    logic [AREA_W-1:0]        r_out;
    logic [AREA_W-1:0]        n_out;
    logic                     r_skid_vld;
    logic                     n_skid_vld;
    logic [AREA_W-1:0]        r_skid;
    logic [AREA_W-1:0]        n_skid;
    logic                     w_take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ecc  <= ECC_RESET;
            r_zone <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ECC:  r_ecc  <= i_cfg_data[ECC_W-1:0];
                CFG_ZONE: r_zone <= i_cfg_data[ZONE_W-1:0];
                default:  ;
            endcase
        end
    end

    // Pipeline advances unless the skid register is holding a word
    assign w_en        = !r_skid_vld;
    assign i_lat.ready = w_en;

    eza_lane u_north (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_lat  (i_lat.north_lat),
        .i_ecc  (r_ecc),
        .i_zone (r_zone),
        .o_g    (w_gn)
    );

    eza_lane u_south (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_lat  (i_lat.south_lat),
        .i_ecc  (r_ecc),
        .i_zone (r_zone),
        .o_g    (w_gs)
    );

    // Valid flags beside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_lat.valid;
        end
    end

    for (genvar i = 1; i < TOP_LAT; i++) begin : g_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (w_en) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // Difference and saturation
    assign w_diff = {w_gn[G_W-1], w_gn} - {w_gs[G_W-1], w_gs};

    always_comb begin
        if (w_diff[G_W:AREA_W-1] == {(G_W-AREA_W+2){w_diff[AREA_W-1]}}) begin
            n_res = w_diff[AREA_W-1:0];
        end else if (w_diff[G_W]) begin
            n_res = {1'b1, {(AREA_W-1){1'b0}}};
        end else begin
            n_res = {1'b0, {(AREA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res <= n_res;
        end
    end

    // Output register and skid
    assign w_take = !r_out_vld || o_area.ready;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_skid_vld = r_skid_vld;
        n_skid     = r_skid;
        if (r_skid_vld) begin
            if (w_take) begin
                n_out_vld  = 1'b1;
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end
        end else if (w_take) begin
            n_out_vld = r_vld[TOP_LAT-1];
            n_out     = r_res;
        end else begin
            n_skid_vld = r_vld[TOP_LAT-1];
            n_skid     = r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_area.valid     = r_out_vld;
    assign o_area.zone_area = r_out;

`ifndef SYNTHESIS
    // Skid only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word without output word");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_skid_vld && !(r_out_vld && !o_area.ready) |=> !r_skid_vld)
        else $error("skid filled while output was free");

    // A waiting output word is not replaced
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_area.ready |=> r_out_vld && $stable(r_out))
        else $error("output word changed while stalled");
`endif

endmodule

### design/eza_div_cell.sv
// One restoring division step: one quotient bit per cycle while i_en is high.
module eza_div_cell import eza_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_div_word i_word,
    output t_div_word o_word
);

    t_div_word   r_word;
    t_div_word   n_word;
    logic [33:0] trial;
    logic        ge;

    // Shift in next dividend bit, subtract divisor if it fits
    always_comb begin
        trial      = {i_word.rem, i_word.dq[63]};
        ge         = (trial >= {1'b0, i_word.den});
        n_word.den = i_word.den;
        n_word.rem = ge ? 33'(trial - {1'b0, i_word.den}) : trial[32:0];
        n_word.dq  = {i_word.dq[62:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

### design/eza_log_cell.sv
// One log2 fraction bit: square the mantissa and renormalize.
module eza_log_cell import eza_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_log_word i_word,
    output t_log_word o_word
);

    t_log_word   r_word;
    t_log_word   n_word;
    logic [63:0] sq;
    logic [32:0] t;

    // m*m in Q31; a carry past 2.0 yields a one bit
    always_comb begin
        sq       = 64'(i_word.m) * 64'(i_word.m);
        t        = sq[63:31];
        n_word.p = i_word.p;
        n_word.m = t[32] ? t[32:1] : t[31:0];
        n_word.f = {i_word.f[30:0], t[32]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

### design/eza_lane.sv
// Per-latitude pipeline: angle, sine, x, x/(1-x^2), atanh and scaling.
module eza_lane import eza_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [LAT_W-1:0]  i_lat,
    input  logic [ECC_W-1:0]         i_ecc,
    input  logic [ZONE_W-1:0]        i_zone,
    output logic signed [G_W-1:0]    o_g
);

    typedef struct packed {
        logic [31:0]        r2;
        logic signed [34:0] sum;
        logic [62:0]        prod;
    } t_sin_a;

    typedef struct packed {
        logic [31:0]        r2;
        logic signed [34:0] sum;
        logic [32:0]        x;
        logic [63:0]        p;
    } t_sin_b;

    typedef struct packed {
        logic [31:0]        r2;
        logic signed [34:0] sum;
        logic [30:0]        term;
    } t_sin_c;

    typedef struct packed {
        logic        big;
        logic [31:0] w;
        logic [4:0]  lz;
    } t_norm;

    // One step of the leading-one search
    function automatic t_norm norm_step(input t_norm a, input int sh);
        logic [31:0] hi;
        t_norm       b;
        b  = a;
        hi = ~(32'hFFFF_FFFF >> sh);
        if (!a.big && ((a.w & hi) == 32'd0)) begin
            b.w  = a.w << sh;
            b.lz = a.lz + 5'(sh);
        end
        return b;
    endfunction

    // Exponent and Q31 mantissa into a log word
    function automatic t_log_word log_init(input t_norm a);
        t_log_word w;
        w.p = a.big ? 6'd32 : 6'd31 - {1'b0, a.lz};
        w.m = a.w;
        w.f = 32'd0;
        return w;
    endfunction

    logic                 r_neg [LANE_LAT-1];
    logic [LAT_W-1:0]     r_mag;
    logic [LAT_W-1:0]     n_mag;
    logic [30:0]          r_rad;
    logic [48:0]          w_rad;
    logic [61:0]          w_sq;
    t_sin_a               r_sa [SIN_TERMS];
    t_sin_b               r_sb [SIN_TERMS];
    t_sin_c               r_sc [SIN_TERMS+1];
    logic [30:0]          w_s;
    logic [62:0]          w_es;
    logic [31:0]          r_u;
    logic [31:0]          r_u2;
    logic [31:0]          r_uu;
    logic [63:0]          w_uu;
    logic [32:0]          w_vp;
    logic [32:0]          w_vm;
    t_div_word            r_div0;
    t_div_word            w_dv [DIV_STEPS+1];
    t_norm                r_np [NORM_STAGES+1];
    t_norm                r_nm [NORM_STAGES+1];
    t_log_word            w_lp [LOG_STEPS+1];
    t_log_word            w_lm [LOG_STEPS+1];
    logic signed [38:0]   w_ldiff;
    logic [37:0]          r_ld;
    logic [61:0]          w_atp;
    logic [36:0]          r_at;
    logic [36:0]          r_dly [AT_DLY];
    logic [63:0]          r_s;
    logic [63:0]          r_pp00;
    logic [63:0]          r_pp01;
    logic [62:0]          r_pp10;
    logic [62:0]          r_pp11;
    logic [64:0]          r_mid;
    logic [126:0]         r_hl;
    logic [126:0]         w_full;
    logic [94:0]          r_w;
    logic signed [G_W-1:0] r_g;

    // Magnitude, clamped to the pole
    always_comb begin
        n_mag = i_lat[LAT_W-1] ? LAT_W'(~i_lat + 1'b1) : i_lat;
        if (32'(n_mag) > LAT_LIMIT) begin
            n_mag = LAT_LIMIT[LAT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag    <= n_mag;
            r_neg[0] <= i_lat[LAT_W-1];
        end
    end

    // Sign travels beside the data
    for (genvar i = 1; i < LANE_LAT - 1; i++) begin : g_neg
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[i] <= r_neg[i-1];
            end
        end
    end

    // Degrees to radians in Q30, then r squared
    assign w_rad = 49'(r_mag) * 49'(DEG2RAD_Q30);
    assign w_sq  = 62'(r_rad) * 62'(r_rad);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad        <= 31'(w_rad >> ANGLE_FRAC_BITS);
            r_sc[0].r2   <= w_sq[61:30];
            r_sc[0].sum  <= $signed({4'd0, r_rad});
            r_sc[0].term <= r_rad;
        end
    end

    // Taylor terms: multiply, reciprocal multiply, correct and accumulate
    for (genvar k = 0; k < SIN_TERMS; k++) begin : g_sin
        logic [62:0]        w_prod;
        logic [32:0]        w_x;
        logic [30:0]        w_q0;
        logic [32:0]        w_rem;
        logic [30:0]        w_q;
        logic signed [34:0] w_t;

        assign w_prod = 63'(r_sc[k].term) * 63'(r_sc[k].r2);
        assign w_x    = r_sa[k].prod[62:30];
        assign w_q0   = r_sb[k].p[63:33];
        assign w_rem  = r_sb[k].x - 33'(39'(w_q0) * 39'(SIN_DIV[k]));
        assign w_q    = (w_rem >= 33'(SIN_DIV[k])) ? w_q0 + 31'd1 : w_q0;
        assign w_t    = $signed({4'd0, w_q});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sa[k].r2     <= r_sc[k].r2;
                r_sa[k].sum    <= r_sc[k].sum;
                r_sa[k].prod   <= w_prod;
                r_sb[k].r2     <= r_sa[k].r2;
                r_sb[k].sum    <= r_sa[k].sum;
                r_sb[k].x      <= w_x;
                r_sb[k].p      <= 64'(w_x) * 64'(SIN_RECIP[k]);
                r_sc[k+1].r2   <= r_sb[k].r2;
                r_sc[k+1].term <= w_q;
                r_sc[k+1].sum  <= ((k % 2) == 0) ? r_sb[k].sum - w_t : r_sb[k].sum + w_t;
            end
        end
    end

    // Clamp sine to [0, 1] and scale by eccentricity
    always_comb begin
        if (r_sc[SIN_TERMS].sum < 0) begin
            w_s = 31'd0;
        end else if (r_sc[SIN_TERMS].sum > 35'sd1073741824) begin
            w_s = 31'd1073741824;
        end else begin
            w_s = r_sc[SIN_TERMS].sum[30:0];
        end
    end

    assign w_es = 63'(i_ecc) * 63'(w_s);
    assign w_uu = 64'(r_u) * 64'(r_u);
    assign w_vp = {1'b1, r_u2};
    assign w_vm = 33'h1_0000_0000 - {1'b0, r_u2};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u        <= w_es[61:30];
            r_u2       <= r_u;
            r_uu       <= w_uu[63:32];
            r_div0.rem <= 33'd0;
            r_div0.dq  <= {r_u2, 32'd0};
            r_div0.den <= 33'h1_0000_0000 - {1'b0, r_uu};
            r_np[0].big <= 1'b1;
            r_np[0].w   <= w_vp[32:1];
            r_np[0].lz  <= 5'd0;
            r_nm[0].big <= w_vm[32];
            r_nm[0].w   <= w_vm[32] ? w_vm[32:1] : w_vm[31:0];
            r_nm[0].lz  <= 5'd0;
        end
    end

    // Division chain: t1 = (u << 32) / d
    assign w_dv[0] = r_div0;
    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        eza_div_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_word (w_dv[i]),
            .o_word (w_dv[i+1])
        );
    end

    // Leading-one search for both log arguments
    for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_np[j+1] <= norm_step(r_np[j], 16 >> j);
                r_nm[j+1] <= norm_step(r_nm[j], 16 >> j);
            end
        end
    end

    // log2 chains for 1+x and 1-x
    assign w_lp[0] = log_init(r_np[NORM_STAGES]);
    assign w_lm[0] = log_init(r_nm[NORM_STAGES]);
    for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
        eza_log_cell u_lp (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_word (w_lp[i]),
            .o_word (w_lp[i+1])
        );
        eza_log_cell u_lm (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_word (w_lm[i]),
            .o_word (w_lm[i+1])
        );
    end

    // atanh = ln2 * (log2(1+x) - log2(1-x)) / 2
    assign w_ldiff = $signed({1'b0, w_lp[LOG_STEPS].p, w_lp[LOG_STEPS].f})
                   - $signed({1'b0, w_lm[LOG_STEPS].p, w_lm[LOG_STEPS].f});
    assign w_atp   = 62'(r_ld) * 62'(LN2_Q24);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ld     <= w_ldiff[38] ? 38'd0 : w_ldiff[37:0];
            r_at     <= w_atp[61:25];
            r_dly[0] <= r_at;
        end
    end

    // Hold atanh until the quotient is done
    for (genvar i = 1; i < AT_DLY; i++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    // M * (t1 + atanh) >> 32, split into 32-bit partial products
    assign w_full = r_hl + (127'(r_mid) << 32);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s    <= w_dv[DIV_STEPS].dq + 64'(r_dly[AT_DLY-1]);
            r_pp00 <= 64'(i_zone[31:0]) * 64'(r_s[31:0]);
            r_pp01 <= 64'(i_zone[31:0]) * 64'(r_s[63:32]);
            r_pp10 <= 63'(i_zone[62:32]) * 63'(r_s[31:0]);
            r_pp11 <= 63'(i_zone[62:32]) * 63'(r_s[63:32]);
            r_mid  <= 65'(r_pp01) + 65'(r_pp10);
            r_hl   <= {r_pp11, r_pp00};
            r_w    <= w_full[126:32];
            r_g    <= r_neg[LANE_LAT-2] ? -$signed({1'b0, r_w}) : $signed({1'b0, r_w});
        end
    end

    assign o_g = r_g;

endmodule

### tb/tb_top.sv
// Self-checking testbench for the ellipsoid zone area pipeline.
module tb_top;
    import eza_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = TOP_LAT + 40;

    typedef struct {
        logic signed [LAT_W-1:0] north;
        logic signed [LAT_W-1:0] south;
    } t_lat_pair;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    eza_in_if  lat_if ();
    eza_out_if area_if ();

    ellipsoid_zone_area dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_lat      (lat_if),
        .o_area     (area_if)
    );

    // Shadow copy of the configuration registers
    logic [ECC_W-1:0]  shadow_ecc;
    logic [ZONE_W-1:0] shadow_zone;

    t_lat_pair                pending_pairs[$];
    logic signed [AREA_W-1:0] area_q[$];
    int  mismatches;
    int  cycles;
    int  hold_cnt;
    bit  no_idle;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Sine of r (Q30 radians) by Taylor series, clamped to [0, 1]
    function automatic logic [63:0] sine_q30(logic [63:0] r);
        logic [63:0] r2;
        logic [63:0] term;
        longint      acc;
        int          k;
        r2 = (r * r) >> 30;
        term = r;
        acc = longint'(r);
        for (k = 1; k <= 6; k++) begin
            term = ((term * r2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > (longint'(1) << 30))
            acc = longint'(1) << 30;
        return 64'(acc);
    endfunction

    // log2 in Q32: leading-one position plus squaring fraction
    function automatic logic [63:0] log2_q32(logic [63:0] v);
        int unsigned p;
        logic [63:0] t;
        logic [63:0] m;
        logic [31:0] f;
        int          i;
        p = 0;
        f = '0;
        if (v == 0)
            v = 1;
        t = v;
        while (t > 1) begin
            t = t >> 1;
            p++;
        end
        m = (p <= 31) ? (v << (31 - p)) : (v >> (p - 31));
        for (i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            f = f << 1;
            if (m >= (64'd1 << 32)) begin
                f[0] = 1'b1;
                m = m >> 1;
            end
        end
        return {p[31:0], f};
    endfunction

    // Signed g(x) for one latitude, at 128 bits
    function automatic logic [127:0] zone_term(logic [LAT_W-1:0] bits);
        logic [63:0]  mag;
        logic [63:0]  r, s, u, d, t1, lp, lm, at;
        longint       ldiff;
        logic [127:0] prod;
        logic [127:0] g;
        mag = bits[LAT_W-1] ? 64'((-bits) & {LAT_W{1'b1}}) : 64'(bits);
        if (bits[LAT_W-1] && mag == 0)
            mag = 64'd1 << (LAT_W - 1);
        if (mag > 64'(LAT_LIMIT))
            mag = 64'(LAT_LIMIT);
        r = (mag * 64'd18740330) >> ANGLE_FRAC_BITS;
        s = sine_q30(r);
        u = (64'(shadow_ecc) * s) >> 30;
        d = (64'd1 << 32) - ((u * u) >> 32);
        t1 = (u << 32) / d;
        lp = log2_q32((64'd1 << 32) + u);
        lm = log2_q32((64'd1 << 32) - u);
        ldiff = longint'(lp) - longint'(lm);
        if (ldiff < 0)
            ldiff = 0;
        at = (64'(ldiff) * 64'd11629080) >> 25;
        prod = 128'(shadow_zone) * 128'(t1 + at);
        g = prod >> 32;
        return bits[LAT_W-1] ? -g : g;
    endfunction

    // Saturated difference g(north) - g(south)
    function automatic logic signed [AREA_W-1:0] zone_area_of(t_lat_pair pr);
        logic [127:0] diff;
        diff = zone_term(pr.north) - zone_term(pr.south);
        if (diff[127:63] == '0 || diff[127:63] == '1)
            return diff[63:0];
        else if (diff[127])
            return {1'b1, 63'd0};
        else
            return {1'b0, {63{1'b1}}};
    endfunction

    // Driver: feeds pending pairs, predicts on accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lat_if.valid <= 1'b0;
        end else begin
            if (lat_if.valid && lat_if.ready)
                area_q.push_back(zone_area_of('{lat_if.north_lat, lat_if.south_lat}));
            if (lat_if.valid && !lat_if.ready) begin
                // hold the word
            end else if (pending_pairs.size() > 0 &&
                         (no_idle || $urandom_range(0, 99) >= 14)) begin
                t_lat_pair pr;
                pr = pending_pairs.pop_front();
                lat_if.valid     <= 1'b1;
                lat_if.north_lat <= pr.north;
                lat_if.south_lat <= pr.south;
            end else begin
                lat_if.valid <= 1'b0;
            end
        end
    end

    // Receiver hold-off counter
    always @(posedge i_clk) begin
        if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    // Monitor: compares each area word with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            area_if.ready <= 1'b0;
        end else begin
            if (area_if.valid && area_if.ready) begin
                if (area_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected area word %0d", area_if.zone_area);
                end else begin
                    logic signed [AREA_W-1:0] want;
                    want = area_q.pop_front();
                    if (area_if.zone_area !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("zone_area: expected %0d, got %0d",
                                     want, area_if.zone_area);
                    end
                end
            end
            area_if.ready <= (hold_cnt <= 1) && (no_idle || $urandom_range(0, 99) >= 14);
        end
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [LAT_W-1:0] rand_lat();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return LAT_W'(int'($urandom_range(0, 11796480)) - 5898240);
        else if (pick < 85)
            return LAT_W'($urandom);
        else
            case ($urandom_range(0, 3))
                0: return LAT_W'(5898240);
                1: return LAT_W'(-5898240);
                2: return '0;
                default: return {1'b1, {(LAT_W-1){1'b0}}};
            endcase
    endfunction

    task automatic wait_idle();
        while (pending_pairs.size() > 0 || area_q.size() > 0 || lat_if.valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One write cycle, then the write strobe drops again before the next write
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_ECC)
            shadow_ecc = data[ECC_W-1:0];
        else
            shadow_zone = data[ZONE_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic push_random(int count);
        t_lat_pair pr;
        int        n;
        for (n = 0; n < count; n++) begin
            pr.north = rand_lat();
            pr.south = ($urandom_range(0, 9) == 0) ? pr.north : rand_lat();
            pending_pairs.push_back(pr);
        end
    endtask

    task automatic run_phase(logic [ECC_W-1:0] ecc, logic [ZONE_W-1:0] zone, int count);
        wait_idle();
        write_reg(CFG_ECC, CFG_W'(ecc));
        write_reg(CFG_ZONE, CFG_W'(zone));
        push_random(count);
    endtask

    initial begin
        t_lat_pair directed[$];
        int        i;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_ECC;
        i_cfg_data = '0;
        lat_if.valid = 1'b0;
        lat_if.north_lat = '0;
        lat_if.south_lat = '0;
        area_if.ready = 1'b0;
        mismatches = 0;
        cycles = 0;
        hold_cnt = 0;
        no_idle = 1'b0;
        shadow_ecc = ECC_RESET;
        shadow_zone = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: zone factor zero, every area is zero
        push_random(20);
        wait_idle();

        // Directed: poles, beyond poles, equal, reversed, field extremes
        write_reg(CFG_ZONE, CFG_W'(63'h0000_0123_4567_89AB));
        directed = '{
            '{24'sd5898240, -24'sd5898240}, '{-24'sd5898240, 24'sd5898240},
            '{24'sh7FFFFF, 24'sh800000}, '{24'sh800000, 24'sh7FFFFF},
            '{24'sd0, 24'sd0}, '{24'sd3000000, 24'sd3000000},
            '{24'sd100, 24'sd5000000}, '{24'sd5000000, 24'sd100},
            '{24'sd1, -24'sd1}, '{24'sd5898241, 24'sd0},
            '{24'sh555555, 24'shAAAAAA}, '{24'shAAAAAA, 24'sh555555},
            '{24'sd0, 24'sh800000}, '{24'sd2949120, -24'sd2949120}
        };
        for (i = 0; i < directed.size(); i++)
            pending_pairs.push_back(directed[i]);
        wait_idle();
        write_reg(CFG_ECC, '1);
        write_reg(CFG_ZONE, {CFG_W{1'b1}});
        for (i = 0; i < directed.size(); i++)
            pending_pairs.push_back(directed[i]);

        // Typical ellipsoid, with a long receiver hold-off
        run_phase(ECC_RESET, 63'h0000_0123_4567_89AB, 250);
        hold_cnt = 400;

        // Saturating extremes, no idling
        run_phase('1, {ZONE_W{1'b1}}, 200);
        no_idle = 1'b1;
        wait_idle();
        no_idle = 1'b0;

        // Smallest eccentricity
        run_phase(32'd1, {ZONE_W{1'b1}}, 150);

        // Random settings
        for (i = 0; i < 3; i++)
            run_phase($urandom | 32'd1,
                      ZONE_W'({$urandom, $urandom} >> (1 + $urandom_range(0, 40))),
                      150);

        wait_idle();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
